// ----- hw/rtl/opf_pkg.sv -----
`timescale 1ns / 1ps
package opf_pkg;
  localparam int unsigned PacketBytesDefault = 4096;
  localparam int unsigned HeaderBytes = 27;
  localparam logic [31:0] CrcPoly = 32'h04C11DB7;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_CLOSE = 2'd1,
    OP_PULL  = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_TOO_LONG = 2'd1,
    ST_DRAINING = 2'd2
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic push;       // store byte at length
    logic close_ok;   // latch header, start crc walk
    logic discard;    // drop packet
    logic crc_step;   // absorb next page byte into crc
    logic crc_done;   // store crc
    logic pull;       // issue page byte to output stage
    logic pull_last;  // last byte: empty buffer
  } opf_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic full;
    logic walk_last;  // crc walk at final byte
    logic read_last;  // read position at final byte
  } opf_sts_t;

  function automatic logic [31:0] crc_byte(logic [31:0] c, logic [7:0] b);
    logic [31:0] r;
    r = c ^ {b, 24'd0};
    for (int k = 0; k < 8; k++) begin
      r = r[31] ? ((r << 1) ^ CrcPoly) : (r << 1);
    end
    return r;
  endfunction
endpackage

// ----- hw/rtl/opf_stream_if.sv -----
`timescale 1ns / 1ps
interface opf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [7:0]  data_byte;
  logic [2:0]  header_flags;
  logic [63:0] granule_position;
  logic [31:0] page_sequence;
  modport source(output valid, opcode, data_byte, header_flags, granule_position,
                 page_sequence, input ready);
  modport sink(input valid, opcode, data_byte, header_flags, granule_position,
               page_sequence, output ready);
endinterface

interface opf_out_if;
  logic       valid;
  logic       ready;
  logic       is_status;
  logic [7:0] page_byte;
  logic       end_of_page;
  logic [1:0] status;
  modport source(output valid, is_status, page_byte, end_of_page, status, input ready);
  modport sink(input valid, is_status, page_byte, end_of_page, status, output ready);
endinterface

interface opf_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

// ----- hw/rtl/opf_datapath.sv -----
`timescale 1ns / 1ps
module opf_datapath #(
  parameter int unsigned PACKET_BYTES = opf_pkg::PacketBytesDefault
) (
  input  logic                clk,
  input  logic                rst_n,
  input  opf_pkg::opf_cmd_t   cmd,
  output opf_pkg::opf_sts_t   sts,
  input  logic [7:0]          in_data_byte,
  input  logic [2:0]          in_header_flags,
  input  logic [63:0]         in_granule_position,
  input  logic [31:0]         in_page_sequence,
  input  logic [31:0]         serial,
  output logic [7:0]          byte_out
);
  localparam int unsigned LenW = $clog2(PACKET_BYTES + 1);
  localparam int unsigned AddrW = (PACKET_BYTES > 1) ? $clog2(PACKET_BYTES) : 1;
  localparam int unsigned PosW = $clog2(PACKET_BYTES + PACKET_BYTES / 255 + 29);
  localparam int unsigned HeaderBytesW = opf_pkg::HeaderBytes;

  logic [7:0]      mem [PACKET_BYTES];
  logic [LenW-1:0] len_r;
  logic [2:0]      flags_r;
  logic [63:0]     gran_r;
  logic [31:0]     seq_r, crc_r, acc_r;
  logic [PosW-1:0] pos_r, walk_r;
  logic [7:0]      nseg_r, full_segs_r, rem_r;

  // segment counts: nseg = len/255+1, computed by a running counter on push
  logic [PosW-1:0] total;

  assign total = PosW'(HeaderBytesW) + PosW'(nseg_r) + PosW'(len_r);

  function automatic logic [7:0] hdr_byte(logic [PosW-1:0] p, logic [31:0] crc,
                                          logic [31:0] ser);
    logic [7:0] b;
    b = 8'd0;
    case (p[4:0])
      5'd0: b = 8'h4F;
      5'd1: b = 8'h67;
      5'd2: b = 8'h67;
      5'd3: b = 8'h53;
      5'd4: b = 8'd0;
      5'd5: b = {5'd0, flags_r};
      5'd6, 5'd7, 5'd8, 5'd9, 5'd10, 5'd11, 5'd12, 5'd13:
        b = gran_r[8*(p[4:0]-5'd6) +: 8];
      5'd14, 5'd15, 5'd16, 5'd17: b = ser[8*(p[4:0]-5'd14) +: 8];
      5'd18, 5'd19, 5'd20, 5'd21: b = seq_r[8*(p[4:0]-5'd18) +: 8];
      5'd22, 5'd23, 5'd24, 5'd25: b = crc[8*(p[4:0]-5'd22) +: 8];
      5'd26: b = nseg_r;
      default: b = 8'd0;
    endcase
    return b;
  endfunction

  // page byte source select for a position; data bytes come from memory
  function automatic logic [1:0] src_of(logic [PosW-1:0] p);
    if (p < PosW'(HeaderBytesW)) return 2'd0;
    if (p < PosW'(HeaderBytesW) + PosW'(nseg_r)) return 2'd1;
    return 2'd2;
  endfunction

  function automatic logic [7:0] seg_byte(logic [PosW-1:0] p);
    logic [PosW-1:0] i;
    i = p - PosW'(HeaderBytesW);
    return (i < PosW'(full_segs_r)) ? 8'hFF : rem_r;
  endfunction

  // memory read address for a position (registered read)
  logic [PosW-1:0] rd_pos;
  logic [AddrW-1:0] rd_addr;
  logic [7:0]      mem_q;
  logic [1:0]      src_q;
  logic [7:0]      alt_q;
  logic            walking_q;
  assign rd_pos  = cmd.crc_step ? walk_r : pos_r;
  assign rd_addr = AddrW'(rd_pos - PosW'(HeaderBytesW) - PosW'(nseg_r));

  always_ff @(posedge clk) begin
    if (cmd.push) mem[len_r[AddrW-1:0]] <= in_data_byte;
    mem_q <= mem[rd_addr];
  end

  // byte of the position fetched in the previous cycle
  logic [7:0] cur_byte;
  assign cur_byte = (src_q == 2'd2) ? mem_q : alt_q;
  assign byte_out = cur_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0; nseg_r <= 8'd1; full_segs_r <= '0; rem_r <= '0;
      flags_r <= '0; gran_r <= '0; seq_r <= '0; crc_r <= '0; acc_r <= '0;
      pos_r <= '0; walk_r <= '0; walking_q <= 1'b0; src_q <= '0; alt_q <= '0;
    end else begin
      walking_q <= cmd.crc_step;
      src_q <= src_of(rd_pos);
      // crc field reads as zero during the walk
      alt_q <= (src_of(rd_pos) == 2'd0) ?
               hdr_byte(rd_pos, cmd.crc_step ? 32'd0 : crc_r, serial) : seg_byte(rd_pos);
      if (walking_q) acc_r <= opf_pkg::crc_byte(acc_r, cur_byte);
      if (cmd.push) begin
        len_r <= len_r + 1'b1;
        if (rem_r == 8'd254) begin
          rem_r <= '0; full_segs_r <= full_segs_r + 1'b1; nseg_r <= nseg_r + 1'b1;
        end else begin
          rem_r <= rem_r + 1'b1;
        end
      end
      if (cmd.close_ok) begin
        flags_r <= in_header_flags; gran_r <= in_granule_position;
        seq_r <= in_page_sequence; acc_r <= '0; walk_r <= '0; pos_r <= '0;
      end
      if (cmd.crc_step) walk_r <= walk_r + 1'b1;
      if (cmd.crc_done) crc_r <= acc_r;
      if (cmd.pull) begin
        pos_r <= cmd.pull_last ? '0 : pos_r + 1'b1;
      end
      if (cmd.discard || (cmd.pull && cmd.pull_last)) begin
        len_r <= '0; nseg_r <= 8'd1; full_segs_r <= '0; rem_r <= '0; pos_r <= '0;
      end
    end
  end

  assign sts.full      = (len_r >= LenW'(PACKET_BYTES));
  assign sts.walk_last = (walk_r + 1'b1 >= total);
  assign sts.read_last = (pos_r + 1'b1 >= total);
endmodule

// ----- hw/rtl/opf_ctrl.sv -----
`timescale 1ns / 1ps
module opf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  opf_in_if.sink            in_ch,
  opf_out_if.source         out_ch,
  output opf_pkg::opf_cmd_t cmd,
  input  opf_pkg::opf_sts_t sts,
  input  logic [7:0]        dp_byte
);
  typedef enum logic [2:0] {S_IDLE, S_WALK, S_WAIT1, S_WAIT2, S_FETCH} state_t;
  state_t     state_r;
  logic       draining_r;
  logic [1:0] err_r;
  logic       ov_r, is_status_r, eop_r;
  logic [1:0] status_r;
  logic [7:0] ob_r;

  logic acc;
  assign in_ch.ready = (state_r == S_IDLE) && !ov_r;
  assign acc = in_ch.valid && in_ch.ready;
  assign out_ch.valid = ov_r;
  assign out_ch.is_status = is_status_r;
  assign out_ch.page_byte = ob_r;
  assign out_ch.end_of_page = eop_r;
  assign out_ch.status = status_r;

  always_comb begin
    cmd = '0;
    if (acc) begin
      case (opf_pkg::opcode_t'(in_ch.opcode))
        opf_pkg::OP_PUSH:  cmd.push = !draining_r && !sts.full;
        opf_pkg::OP_CLOSE: begin
          cmd.close_ok = (err_r == opf_pkg::ST_OK);
          cmd.discard  = (err_r != opf_pkg::ST_OK);
        end
        opf_pkg::OP_PULL: begin
          cmd.pull = draining_r;
          cmd.pull_last = draining_r && sts.read_last;
        end
        default: ;
      endcase
    end
    if (state_r == S_WALK) begin
      cmd.crc_step = 1'b1;
    end
    if (state_r == S_WAIT2) cmd.crc_done = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; draining_r <= 1'b0; err_r <= '0; ov_r <= 1'b0;
      is_status_r <= 1'b0; eop_r <= 1'b0; status_r <= '0; ob_r <= '0;
    end else begin
      if (ov_r && out_ch.ready) ov_r <= 1'b0;
      case (state_r)
        S_IDLE: if (acc) begin
          case (opf_pkg::opcode_t'(in_ch.opcode))
            opf_pkg::OP_PUSH: begin
              if (draining_r && err_r == opf_pkg::ST_OK) err_r <= opf_pkg::ST_DRAINING;
              else if (!draining_r && sts.full && err_r == opf_pkg::ST_OK)
                err_r <= opf_pkg::ST_TOO_LONG;
            end
            opf_pkg::OP_CLOSE: begin
              is_status_r <= 1'b1; eop_r <= 1'b0; ob_r <= '0; status_r <= err_r;
              if (err_r != opf_pkg::ST_OK) begin
                err_r <= opf_pkg::ST_OK; draining_r <= 1'b0; ov_r <= 1'b1;
              end else begin
                draining_r <= 1'b1; state_r <= S_WALK;
              end
            end
            opf_pkg::OP_PULL: if (draining_r) begin
              is_status_r <= 1'b0; status_r <= '0; eop_r <= sts.read_last;
              if (sts.read_last) draining_r <= 1'b0;
              state_r <= S_FETCH;
            end
            default: ;
          endcase
        end
        S_WALK: if (sts.walk_last) state_r <= S_WAIT1;
        S_WAIT1: state_r <= S_WAIT2;
        S_WAIT2: begin ov_r <= 1'b1; state_r <= S_IDLE; end
        S_FETCH: begin ob_r <= dp_byte; ov_r <= 1'b1; state_r <= S_IDLE; end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !out_ch.ready |=> ov_r) else $error("result dropped");
  a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !in_ch.ready) else $error("accept while busy");
  a_walk_drain: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WALK |-> draining_r) else $error("crc walk without page");
endmodule

// ----- hw/rtl/ogg_page_framer.sv -----
`timescale 1ns / 1ps
// Ogg page framer: wraps one packet in one Ogg page.
// in channel (opf_in_if): opcode push loads data_byte into the packet
//   buffer, close latches flags/granule/sequence and computes the page
//   CRC, pull returns the next page byte. One beat per item.
// out channel (opf_out_if): a close answers with a status beat, a pull
//   while a page is draining answers with a page byte, end_of_page on the
//   last one. Push and idle pulls give no beat.
// cfg channel: 32-bit stream serial, reset value 1; write only while idle.
// Flow: a push leaves the framer idle; a pull passes through the fetch
//   state and then waits while the receiver holds ready low. A close
//   without error walks the page once through the packet RAM read port,
//   one byte per cycle, then S_WAIT1 and S_WAIT2 finish the CRC before the status beat.
// Reset (synchronous, rst_n low) empties the buffer, clears the latched
//   header and errors, and sets the serial to 1.
// While the result beat is not taken, in_ready stays low.
module ogg_page_framer #(
  parameter int unsigned PACKET_BYTES = opf_pkg::PacketBytesDefault
) (
  input  logic       clk,
  input  logic       rst_n,
  opf_in_if.sink     in_ch,
  opf_out_if.source  out_ch,
  opf_cfg_if.sink    cfg_ch
);
  opf_pkg::opf_cmd_t cmd;
  opf_pkg::opf_sts_t sts;
  logic [31:0] serial_r;
  logic [7:0]  dp_byte;

  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) serial_r <= 32'd1;
    else if (cfg_ch.valid) serial_r <= cfg_ch.data;
  end

  opf_ctrl u_ctrl (
    .clk, .rst_n, .in_ch, .out_ch, .cmd, .sts, .dp_byte
  );

  opf_datapath #(.PACKET_BYTES(PACKET_BYTES)) u_dp (
    .clk, .rst_n, .cmd, .sts,
    .in_data_byte(in_ch.data_byte), .in_header_flags(in_ch.header_flags),
    .in_granule_position(in_ch.granule_position),
    .in_page_sequence(in_ch.page_sequence), .serial(serial_r),
    .byte_out(dp_byte)
  );
endmodule
